FILE: hdl/pthc_pkg.sv
// Package with shared types, register indexes and helpers for the compensation pipeline.
package pthc_pkg;

  // Configuration register indexes.
  localparam logic [2:0] RegTempCalib   = 3'd0;
  localparam logic [2:0] RegPressCalibA = 3'd1;
  localparam logic [2:0] RegPressCalibB = 3'd2;
  localparam logic [2:0] RegPressNine   = 3'd3;
  localparam logic [2:0] RegHumCalib    = 3'd4;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned QuotW    = 32;

  localparam logic [31:0] HumMax = 32'd419430400;

  // Unpacked calibration words, each sign or zero extended to 32 bits.
  typedef struct packed {
    logic signed [31:0] t1, t2, t3;
    logic signed [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [31:0] h1, h2, h3, h4, h5, h6;
  } calib_t;

  // Low 32 bits of a signed product.
  function automatic logic signed [31:0] mul32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

endpackage

FILE: hdl/pthc_divider.sv
// Pipelined restoring divider, one quotient bit per stage, for the pressure quotient.
module pthc_divider (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [pthc_pkg::QuotW-1:0] num_i,
  input  logic [pthc_pkg::QuotW-1:0] den_i,
  output logic [pthc_pkg::QuotW-1:0] quot_o
);

  localparam int unsigned N = pthc_pkg::QuotW;

  // The last stage only produces the final quotient bit, so it keeps no remainder.
  logic [N-1:0] rem_q [N-1];
  logic [N-1:0] den_q [N-1];
  logic [N-1:0] num_q [N];

  // One stage per quotient bit; the numerator shifts out its bits as the quotient shifts in.
  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [N-1:0] rem_in;
    logic [N-1:0] num_in;
    logic [N-1:0] den_in;
    logic [N:0]   trial;
    logic [N:0]   diff;
    logic         q_bit;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign num_in = num_q[s-1];
      assign den_in = den_q[s-1];
    end

    assign trial = {rem_in, num_in[N-1]};
    assign diff  = trial - {1'b0, den_in};
    assign q_bit = !diff[N];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s] <= {num_in[N-2:0], q_bit};
      end
    end

    // Partial remainder and divisor move on to the next stage.
    if (s < N - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= q_bit ? diff[N-1:0] : trial[N-1:0];
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign quot_o = num_q[N-1];

endmodule

FILE: hdl/pth_sensor_compensation_top.sv
// Top level of the temperature, pressure and humidity compensation pipeline.
//
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | raw_temp, raw_press, raw_hum
// out     | output    | out_valid/out_ready| fine_temp, temp_centi, press_pa, press_invalid, hum_q10
// cfg     | input     | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// One item enters per cycle while the output is not stalled; the pipeline is 46 register
// stages deep, set by the 32 stages of the bit-per-stage pressure divider plus 14
// arithmetic stages, each at most one multiply deep.
// Reset clears the calibration registers and all stage valid bits.
// A stall at the output freezes the whole pipeline; ready is low only while the
// last stage holds an item that is not taken, so nothing is lost or repeated.
module pth_sensor_compensation_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] raw_temp_i,
  input  logic [19:0] raw_press_i,
  input  logic [15:0] raw_hum_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] fine_temp_o,
  output logic signed [31:0] temp_centi_o,
  output logic [31:0] press_pa_o,
  output logic        press_invalid_o,
  output logic [16:0] hum_q10_o,
  input  logic        cfg_we_i,
  input  logic [pthc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pthc_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned Pre  = 9;   // stages before the divider
  localparam int unsigned DivL = pthc_pkg::QuotW;
  localparam int unsigned Post = 5;   // stages after the divider
  localparam int unsigned Depth = Pre + DivL + Post;

  // Calibration registers.
  logic [47:0] temp_calib_q;
  logic [63:0] press_a_q, press_b_q, hum_calib_q;
  logic [15:0] press_nine_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_calib_q <= '0;
      press_a_q    <= '0;
      press_b_q    <= '0;
      press_nine_q <= '0;
      hum_calib_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pthc_pkg::RegTempCalib:   temp_calib_q <= cfg_data_i[47:0];
        pthc_pkg::RegPressCalibA: press_a_q    <= cfg_data_i;
        pthc_pkg::RegPressCalibB: press_b_q    <= cfg_data_i;
        pthc_pkg::RegPressNine:   press_nine_q <= cfg_data_i[15:0];
        pthc_pkg::RegHumCalib:    hum_calib_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pthc_pkg::calib_t c;
  always_comb begin
    c.t1 = {16'd0, temp_calib_q[15:0]};
    c.t2 = {{16{temp_calib_q[31]}}, temp_calib_q[31:16]};
    c.t3 = {{16{temp_calib_q[47]}}, temp_calib_q[47:32]};
    c.p1 = {16'd0, press_a_q[15:0]};
    c.p2 = {{16{press_a_q[31]}}, press_a_q[31:16]};
    c.p3 = {{16{press_a_q[47]}}, press_a_q[47:32]};
    c.p4 = {{16{press_a_q[63]}}, press_a_q[63:48]};
    c.p5 = {{16{press_b_q[15]}}, press_b_q[15:0]};
    c.p6 = {{16{press_b_q[31]}}, press_b_q[31:16]};
    c.p7 = {{16{press_b_q[47]}}, press_b_q[47:32]};
    c.p8 = {{16{press_b_q[63]}}, press_b_q[63:48]};
    c.p9 = {{16{press_nine_q[15]}}, press_nine_q};
    c.h1 = {24'd0, hum_calib_q[7:0]};
    c.h2 = {{16{hum_calib_q[23]}}, hum_calib_q[23:8]};
    c.h3 = {24'd0, hum_calib_q[31:24]};
    c.h4 = {{20{hum_calib_q[43]}}, hum_calib_q[43:32]};
    c.h5 = {{20{hum_calib_q[55]}}, hum_calib_q[55:44]};
    c.h6 = {{24{hum_calib_q[63]}}, hum_calib_q[63:56]};
  end

  // Global stall: the pipeline advances whenever the last stage is empty or taken.
  logic adv;
  logic [Depth-1:0] vld_q;
  assign adv      = !vld_q[Depth-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_valid};
    end
  end

  // Pre-divider stages: temperature, then pressure and humidity terms.
  typedef struct packed {
    logic signed [31:0] at, ap, ah;
    logic signed [31:0] a, b, e, f, g, k;
    logic signed [31:0] fine, tc, x, hv1;
  } pre_t;

  pre_t s_q [Pre];
  pre_t s_d [Pre];

  always_comb begin
    s_d[0] = '0;
    for (int i = 1; i < Pre; i++) s_d[i] = s_q[i-1];
    // S0: operands of the temperature products.
    s_d[0].at = {12'd0, raw_temp_i};
    s_d[0].ap = {12'd0, raw_press_i};
    s_d[0].ah = {16'd0, raw_hum_i};
    s_d[0].a  = ($signed({12'd0, raw_temp_i}) >>> 3) - (c.t1 <<< 1);
    s_d[0].b  = ($signed({12'd0, raw_temp_i}) >>> 4) - c.t1;
    // S1
    s_d[1].a = pthc_pkg::mul32(s_q[0].a, c.t2) >>> 11;
    s_d[1].b = pthc_pkg::mul32(s_q[0].b, s_q[0].b) >>> 12;
    // S2
    s_d[2].b    = pthc_pkg::mul32(s_q[1].b, c.t3) >>> 14;
    s_d[2].fine = s_q[1].a + s_d[2].b;
    // S3: fine temperature known; start pressure and humidity.
    s_d[3].tc = (pthc_pkg::mul32(s_q[2].fine, 32'sd5) + 32'sd128) >>> 8;
    s_d[3].a  = (s_q[2].fine >>> 1) - 32'sd64000;
    s_d[3].x  = s_q[2].fine - 32'sd76800;
    // S4: d = (v1>>2)^2, v1*p5, p2*v1, humidity x*h3, x*h5, x*h6.
    s_d[4].b = pthc_pkg::mul32(s_q[3].a >>> 2, s_q[3].a >>> 2);
    s_d[4].e = pthc_pkg::mul32(s_q[3].a, c.p5) <<< 1;
    s_d[4].f = pthc_pkg::mul32(c.p2, s_q[3].a) >>> 1;
    s_d[4].g = pthc_pkg::mul32(s_q[3].x, c.h6) >>> 10;
    s_d[4].k = (pthc_pkg::mul32(s_q[3].x, c.h3) >>> 11) + 32'sd32768;
    s_d[4].hv1 = (((s_q[3].ah <<< 14) - (c.h4 <<< 20)) -
                  pthc_pkg::mul32(c.h5, s_q[3].x) + 32'sd16384) >>> 15;
    // S5
    s_d[5].e = ((pthc_pkg::mul32(s_q[4].b >>> 11, c.p6) + s_q[4].e) >>> 2) +
               (c.p4 <<< 16);
    s_d[5].f = ((pthc_pkg::mul32(c.p3, s_q[4].b >>> 13) >>> 3) + s_q[4].f) >>> 18;
    s_d[5].g = (pthc_pkg::mul32(s_q[4].g, s_q[4].k) >>> 10) + 32'sd2097152;
    // S6
    s_d[6].f = pthc_pkg::mul32(32'sd32768 + s_q[5].f, c.p1) >>> 15;
    s_d[6].g = (pthc_pkg::mul32(s_q[5].g, c.h2) + 32'sd8192) >>> 14;
    s_d[6].a = (32'sd1048576 - s_q[5].ap) - (s_q[5].e >>> 12);
    // S7: pressure numerator, humidity product.
    s_d[7].a = pthc_pkg::mul32(s_q[6].a, 32'sd3125);
    s_d[7].x = pthc_pkg::mul32(s_q[6].hv1, s_q[6].g);
    // S8: divider operand prep, humidity correction square.
    s_d[8].a = s_q[7].a[31] ? s_q[7].a : (s_q[7].a <<< 1);
    s_d[8].k = pthc_pkg::mul32(s_q[7].x >>> 15, s_q[7].x >>> 15) >>> 7;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < Pre; i++) s_q[i] <= s_d[i];
    end
  end

  // Side values carried alongside the divider.
  typedef struct packed {
    logic signed [31:0] fine, tc, x, k;
    logic        inv;
    logic        big;
  } side_t;

  // Whether the numerator takes the divide-then-double path; travels with stage S8.
  logic big_q;

  side_t side_q [DivL];
  side_t side_in;
  always_comb begin
    side_in.fine = s_q[8].fine;
    side_in.tc   = s_q[8].tc;
    side_in.x    = s_q[8].x;
    side_in.k    = s_q[8].k;
    side_in.inv  = (s_q[8].f == 32'sd0);
    side_in.big  = big_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      big_q     <= s_q[7].a[31];
      side_q[0] <= side_in;
      for (int i = 1; i < DivL; i++) side_q[i] <= side_q[i-1];
    end
  end

  logic [pthc_pkg::QuotW-1:0] quot;
  pthc_divider u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (s_q[8].a),
    .den_i (s_q[8].f),
    .quot_o(quot)
  );

  // Post-divider stages: pressure refinement, humidity correction and clamp.
  typedef struct packed {
    logic signed [31:0] fine, tc, x, p, v1, v2;
    logic        inv;
  } post_t;

  post_t t_q [Post];
  post_t t_d [Post];
  logic [31:0] p0, p3s;
  logic signed [31:0] hx;

  always_comb begin
    t_d[0] = '0;
    for (int i = 1; i < Post; i++) t_d[i] = t_q[i-1];
    p0 = side_q[DivL-1].big ? (quot << 1) : quot;
    t_d[0].fine = side_q[DivL-1].fine;
    t_d[0].tc   = side_q[DivL-1].tc;
    t_d[0].inv  = side_q[DivL-1].inv;
    t_d[0].p    = p0;
    t_d[0].x    = side_q[DivL-1].x - (pthc_pkg::mul32(side_q[DivL-1].k,
                                                      c.h1) >>> 4);
    p3s = t_q[0].p >> 3;
    t_d[1].v1 = pthc_pkg::mul32(p3s, p3s);
    t_d[1].v2 = pthc_pkg::mul32($signed(t_q[0].p >> 2), c.p8) >>> 13;
    t_d[2].v1 = pthc_pkg::mul32(c.p9, $signed(t_q[1].v1 >> 13)) >>> 12;
    t_d[3].p  = t_q[2].p + ((t_q[2].v1 + t_q[2].v2 + c.p7) >>> 4);
    hx = t_q[3].x;
    if (hx < 0) hx = 0;
    if ($unsigned(hx) > pthc_pkg::HumMax) hx = pthc_pkg::HumMax;
    t_d[4].x = hx;
    if (t_q[3].inv) t_d[4].p = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < Post; i++) t_q[i] <= t_d[i];
    end
  end

  assign fine_temp_o     = t_q[Post-1].fine;
  assign temp_centi_o    = t_q[Post-1].tc;
  assign press_pa_o      = t_q[Post-1].p;
  assign press_invalid_o = t_q[Post-1].inv;
  assign hum_q10_o       = t_q[Post-1].x[28:12];

  // A stalled result must hold.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(press_pa_o));
  // Invalid pressure always reads zero.
  a_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && press_invalid_o |-> press_pa_o == 32'd0);
  // Humidity never exceeds full scale.
  a_hum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> hum_q10_o <= 17'd102400);
  // Input is refused only when the output is stalled.
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready);

endmodule
